FILE: rtl/core/nsc_pkg.sv
package nsc_pkg;

  localparam int PrefixLen   = 6;
  localparam int PrefixCount = 5;

  localparam logic [7:0] CharDollar = 8'h24;
  localparam logic [7:0] CharStar   = 8'h2A;

  // one row per known sentence type, in type order
  localparam logic [7:0] PREFIX_TABLE [PrefixCount][PrefixLen] = '{
    '{8'h24, 8'h47, 8'h50, 8'h47, 8'h47, 8'h41},  // $GPGGA
    '{8'h24, 8'h47, 8'h50, 8'h47, 8'h53, 8'h41},  // $GPGSA
    '{8'h24, 8'h47, 8'h50, 8'h47, 8'h53, 8'h56},  // $GPGSV
    '{8'h24, 8'h47, 8'h50, 8'h52, 8'h4D, 8'h43},  // $GPRMC
    '{8'h24, 8'h47, 8'h50, 8'h56, 8'h54, 8'h47}   // $GPVTG
  };

  typedef enum logic [1:0] {
    PH_BODY = 2'd0,
    PH_HEX  = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ERR_OK       = 3'd0,
    ERR_NO_DOLLAR = 3'd1,
    ERR_NO_STAR  = 3'd2,
    ERR_NO_HEX   = 3'd3,
    ERR_MISMATCH = 3'd4
  } err_t;

  localparam logic [2:0] TYPE_INVALID = 3'd0;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t r;
    r.is_hex = 1'b1;
    r.value  = 4'd0;
    case (c) inside
      [8'h30:8'h39]: r.value = c[3:0];
      [8'h41:8'h46], [8'h61:8'h66]: r.value = c[3:0] + 4'd9;
      default: r.is_hex = 1'b0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/nsc_if.sv
interface nsc_in_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, output data_byte, output frame_end, input ready);
  modport sink (input valid, input data_byte, input frame_end, output ready);
endinterface

interface nsc_out_if (input logic clk);
  logic       valid;
  logic       ready;
  logic       sentence_ok;
  logic [2:0] sentence_type;
  logic [2:0] error_reason;
  logic [7:0] computed_sum;
  logic [7:0] received_sum;

  modport source (output valid, output sentence_ok, output sentence_type,
                  output error_reason, output computed_sum, output received_sum,
                  input ready);
  modport sink (input valid, input sentence_ok, input sentence_type,
                input error_reason, input computed_sum, input received_sum,
                output ready);
endinterface

FILE: rtl/core/nmea_sentence_checker_top.sv
// output: the verdict is registered and appears in the cycle after the item carrying frame_end is taken
// throughput: one item per cycle while the receiver keeps up; input stalls in every
//   cycle that a verdict waits in the result register and the receiver is not ready
// reset: synchronous, active-high rst clears the sentence state and the result valid
module nmea_sentence_checker_top (
  input logic      clk,
  input logic      rst,
  nsc_in_if.sink   in_ch,
  nsc_out_if.source out_ch
);

  logic [2:0]                         byte_position, byte_position_next;
  nsc_pkg::phase_t                    phase, phase_next;
  logic [7:0]                         running_xor, running_xor_next;
  logic [nsc_pkg::PrefixCount-1:0]    prefix_matches, prefix_matches_next;
  logic [7:0]                         hex_value, hex_value_next;
  logic [1:0]                         hex_digits_seen, hex_digits_seen_next;
  logic                               dollar_seen, dollar_seen_next;

  logic       out_valid;
  logic       res_ok;
  logic [2:0] res_type;
  logic [2:0] res_reason;

  logic                accept;
  nsc_pkg::hex_digit_t digit;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign digit       = nsc_pkg::hex_decode(in_ch.data_byte);

  // sentence state after taking this byte
  always_comb begin
    byte_position_next   = byte_position;
    phase_next           = phase;
    running_xor_next     = running_xor;
    prefix_matches_next  = prefix_matches;
    hex_value_next       = hex_value;
    hex_digits_seen_next = hex_digits_seen;
    dollar_seen_next     = dollar_seen;

    if (byte_position < 3'(nsc_pkg::PrefixLen)) begin
      for (int k = 0; k < nsc_pkg::PrefixCount; k++) begin
        if (nsc_pkg::PREFIX_TABLE[k][byte_position] != in_ch.data_byte) begin
          prefix_matches_next[k] = 1'b0;
        end
      end
    end

    if (byte_position == 3'd0) begin
      dollar_seen_next = (in_ch.data_byte == nsc_pkg::CharDollar);
    end else begin
      case (phase)
        nsc_pkg::PH_BODY: begin
          if (in_ch.data_byte == nsc_pkg::CharStar) begin
            phase_next = nsc_pkg::PH_HEX;
          end else begin
            running_xor_next = running_xor ^ in_ch.data_byte;
          end
        end
        nsc_pkg::PH_HEX: begin
          if (!digit.is_hex) begin
            phase_next = nsc_pkg::PH_DONE;
          end else begin
            hex_value_next       = {hex_value[3:0], digit.value};
            hex_digits_seen_next = hex_digits_seen + 2'd1;
            if (hex_digits_seen != 2'd0) begin
              phase_next = nsc_pkg::PH_DONE;
            end
          end
        end
        default: ;
      endcase
    end

    if (byte_position != 3'd7) begin
      byte_position_next = byte_position + 3'd1;
    end
  end

  // verdict from the state that includes the final byte
  always_comb begin
    res_ok   = 1'b0;
    res_type = nsc_pkg::TYPE_INVALID;
    if (!dollar_seen_next) begin
      res_reason = nsc_pkg::ERR_NO_DOLLAR;
    end else if (phase_next == nsc_pkg::PH_BODY) begin
      res_reason = nsc_pkg::ERR_NO_STAR;
    end else if (hex_digits_seen_next == 2'd0) begin
      res_reason = nsc_pkg::ERR_NO_HEX;
    end else if (running_xor_next != hex_value_next) begin
      res_reason = nsc_pkg::ERR_MISMATCH;
    end else begin
      res_reason = nsc_pkg::ERR_OK;
      res_ok     = 1'b1;
    end

    if (res_ok && byte_position_next >= 3'(nsc_pkg::PrefixLen)) begin
      for (int k = nsc_pkg::PrefixCount - 1; k >= 0; k--) begin
        if (prefix_matches_next[k]) begin
          res_type = 3'(k + 1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= 3'd0;
      phase           <= nsc_pkg::PH_BODY;
      running_xor     <= 8'd0;
      prefix_matches  <= '1;
      hex_value       <= 8'd0;
      hex_digits_seen <= 2'd0;
      dollar_seen     <= 1'b0;
    end else if (accept) begin
      if (in_ch.frame_end) begin
        // start over for the next sentence
        byte_position   <= 3'd0;
        phase           <= nsc_pkg::PH_BODY;
        running_xor     <= 8'd0;
        prefix_matches  <= '1;
        hex_value       <= 8'd0;
        hex_digits_seen <= 2'd0;
        dollar_seen     <= 1'b0;
      end else begin
        byte_position   <= byte_position_next;
        phase           <= phase_next;
        running_xor     <= running_xor_next;
        prefix_matches  <= prefix_matches_next;
        hex_value       <= hex_value_next;
        hex_digits_seen <= hex_digits_seen_next;
        dollar_seen     <= dollar_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && in_ch.frame_end) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_ch.frame_end) begin
      out_ch.sentence_ok   <= res_ok;
      out_ch.sentence_type <= res_type;
      out_ch.error_reason  <= res_reason;
      out_ch.computed_sum  <= running_xor_next;
      out_ch.received_sum  <= hex_value_next;
    end
  end

  assign out_ch.valid = out_valid;

`ifndef SYNTH
  a_type_needs_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ch.sentence_type != nsc_pkg::TYPE_INVALID |-> out_ch.sentence_ok)
    else $error("sentence type given without a good checksum");

  a_ok_matches_reason: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_ch.sentence_ok == (out_ch.error_reason == nsc_pkg::ERR_OK)))
    else $error("ok flag disagrees with error reason");

  a_verdict_follows_end: assert property (@(posedge clk) disable iff (rst)
    accept && in_ch.frame_end |=> out_valid && byte_position == 3'd0 && dollar_seen == 1'b0)
    else $error("final byte did not produce a verdict and restart");

  a_hex_count_bound: assert property (@(posedge clk) disable iff (rst)
    hex_digits_seen != 2'd3 && (hex_digits_seen == 2'd0 || phase != nsc_pkg::PH_BODY))
    else $error("hex digit count out of step with phase");
`endif

endmodule
